@@ sv/julia_escape_time_pixel_assert.svh @@
// Assertion macros shared by the checker of julia_escape_time_pixel.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JET_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define JET_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ sv/jet_pkg.sv @@
// Package for the Julia escape-time pixel block: register indexes, reset values,
// level table, color mapping and saturation helper. No dependencies.
package jet_pkg;

	typedef enum logic [2:0] {
		CFG_C_REAL   = 3'd0,
		CFG_C_IMAG   = 3'd1,
		CFG_X_START  = 3'd2,
		CFG_X_END    = 3'd3,
		CFG_Y_BOTTOM = 3'd4,
		CFG_Y_TOP    = 3'd5,
		CFG_WIDTH    = 3'd6,
		CFG_MAX_ITER = 3'd7
	} cfg_idx_t;

	localparam logic [31:0] C_REAL_RST   = 32'h0000_0000;
	localparam logic [31:0] C_IMAG_RST   = 32'h0000_0000;
	localparam logic [31:0] X_START_RST  = 32'hF800_0000;
	localparam logic [31:0] X_END_RST    = 32'h0800_0000;
	localparam logic [31:0] Y_BOTTOM_RST = 32'hF800_0000;
	localparam logic [31:0] Y_TOP_RST    = 32'h0800_0000;
	localparam logic [11:0] WIDTH_RST    = 12'd640;
	localparam logic [15:0] MAX_ITER_RST = 16'd256;

	// width of the sums that are clamped back to 32 bits
	localparam int SAT_W = 67;

	localparam logic [7:0] COL_LO = 8'd55;
	localparam logic [7:0] COL_HI = 8'd255;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// floor(500*log10(n)) for n = 1..100
	localparam logic [9:0] LEVEL_TAB [0:99] = '{
		10'd0,   10'd150, 10'd238, 10'd301, 10'd349, 10'd389, 10'd422, 10'd451, 10'd477, 10'd500,
		10'd520, 10'd539, 10'd556, 10'd573, 10'd588, 10'd602, 10'd615, 10'd627, 10'd639, 10'd650,
		10'd661, 10'd671, 10'd680, 10'd690, 10'd698, 10'd707, 10'd715, 10'd723, 10'd731, 10'd738,
		10'd745, 10'd752, 10'd759, 10'd765, 10'd772, 10'd778, 10'd784, 10'd789, 10'd795, 10'd801,
		10'd806, 10'd811, 10'd816, 10'd821, 10'd826, 10'd831, 10'd836, 10'd840, 10'd845, 10'd849,
		10'd853, 10'd858, 10'd862, 10'd866, 10'd870, 10'd874, 10'd877, 10'd881, 10'd885, 10'd889,
		10'd892, 10'd896, 10'd899, 10'd903, 10'd906, 10'd909, 10'd913, 10'd916, 10'd919, 10'd922,
		10'd925, 10'd928, 10'd931, 10'd934, 10'd937, 10'd940, 10'd943, 10'd946, 10'd948, 10'd951,
		10'd954, 10'd956, 10'd959, 10'd962, 10'd964, 10'd967, 10'd969, 10'd972, 10'd974, 10'd977,
		10'd979, 10'd981, 10'd984, 10'd986, 10'd988, 10'd991, 10'd993, 10'd995, 10'd997, 10'd1000
	};

	// piecewise palette over levels 0..1000
	function automatic rgb_t colour_map(input logic [9:0] lv);
		rgb_t c;
		logic [9:0] d;
		if (lv > 10'd800) begin
			d = lv - 10'd800;
			c.r = COL_HI;
			c.g = COL_LO + d[7:0];
			c.b = COL_LO + d[7:0];
		end else if (lv > 10'd600) begin
			d = lv - 10'd600;
			c.r = COL_HI;
			c.g = COL_HI - d[7:0];
			c.b = COL_LO;
		end else if (lv > 10'd400) begin
			d = lv - 10'd400;
			c.r = COL_LO + d[7:0];
			c.g = COL_HI;
			c.b = COL_LO;
		end else if (lv > 10'd200) begin
			d = lv - 10'd200;
			c.r = COL_LO;
			c.g = COL_HI;
			c.b = COL_HI - d[7:0];
		end else begin
			d = lv;
			c.r = COL_LO;
			c.g = COL_LO + d[7:0];
			c.b = COL_HI;
		end
		return c;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-32:0] top;
		logic signed [31:0] r;
		top = v[SAT_W-1:31];
		if ((&top) || !(|top)) begin
			r = v[31:0];
		end else if (v[SAT_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

@@ sv/julia_escape_time_pixel.sv @@
// Julia escape-time pixel colorer: one pixel per command, one 33x33 signed multiplier
// and one radix-2 divider shared under a one-hot sequencer. Depends on jet_pkg.
//
// channel  | signals                                   | transaction
// ---------+-------------------------------------------+------------------------------
// command  | start, busy, row, col                     | start && !busy at clk rise
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
// result   | done, red, green, blue, in_image          | done high for one cycle
//
// Per pixel: a column outside the width never raises busy, result next cycle.
// Otherwise a divider pass for the step, one for the height, the start point, then
// per iteration the shared multiplier (x*x, y*y, x*y, update). Zero step ends after
// the step pass, a row outside the height after the height pass. Non-escaping ends
// at max_iter; escaping after t steps adds a palette index divider pass.
// done pulses in the same cycle that busy drops. Reset is asynchronous and loads the
// register defaults; results are never stalled, config is always ready.
module julia_escape_time_pixel #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 26
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_BITS-1:0]  row,
	input  logic [COORD_BITS-1:0]  col,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  jet_pkg::cfg_idx_t      cfg_index,
	input  logic [31:0]            cfg_data,
	output logic                   done,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   in_image
);
	import jet_pkg::*;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int PW     = PROD_W - FRAC_BITS;
	localparam int EW     = PW + 1;
	localparam int NW     = PW + 2;
	localparam int CW     = (COORD_BITS > 12) ? COORD_BITS : 12;
	localparam int DIV_W  = 32;
	localparam int CNT_W  = $clog2(DIV_W);
	localparam logic signed [EW-1:0] FOUR = EW'(1) <<< (FRAC_BITS + 2);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00_0000_0000_0001,
		S_DIV_STEP = 14'b00_0000_0000_0010,
		S_STEP_END = 14'b00_0000_0000_0100,
		S_DIV_HGT  = 14'b00_0000_0000_1000,
		S_HGT_END  = 14'b00_0000_0001_0000,
		S_MX       = 14'b00_0000_0010_0000,
		S_MY       = 14'b00_0000_0100_0000,
		S_Y0       = 14'b00_0000_1000_0000,
		S_XX       = 14'b00_0001_0000_0000,
		S_YY       = 14'b00_0010_0000_0000,
		S_XY       = 14'b00_0100_0000_0000,
		S_UPD      = 14'b00_1000_0000_0000,
		S_DIV_K    = 14'b01_0000_0000_0000,
		S_K_END    = 14'b10_0000_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic signed [31:0] c_real_q, c_imag_q, x_start_q, x_end_q, y_bottom_q, y_top_q;
	logic [11:0] width_q;
	logic [15:0] max_iter_q;

	logic [COORD_BITS-1:0] row_q, col_q;
	logic signed [MUL_W-1:0] step_q;
	logic xneg_q, hneg_q;
	logic signed [31:0] x_q, y_q;
	logic [15:0] t_q;
	logic signed [PW-1:0] xx_q, yy_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DIV_W-1:0] div_rem_q, div_quo_q, div_den_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [7:0] red_q, green_q, blue_q;
	logic in_image_q, done_q;

	logic accept, col_out, div_last, quo_zero, inside_h, iter_end, escape, finish;
	logic signed [32:0] xdiff, ydiff;
	logic [32:0] xdiff_neg, ydiff_neg;
	logic [DIV_W-1:0] xdiff_mag, ydiff_mag;
	logic [DIV_W:0] div_trial;
	logic div_ge;
	logic [DIV_W-1:0] div_rem_next;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PW-1:0] prod_sh;
	logic signed [31:0] start_x, start_y, next_x, next_y;
	logic signed [EW-1:0] esc_sum;
	logic signed [NW-1:0] nx, ny;
	logic [22:0] t100;
	rgb_t rgb;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign col_out   = CW'(col) >= CW'(width_q);

	assign xdiff     = 33'(x_end_q) - 33'(x_start_q);
	assign ydiff     = 33'(y_top_q) - 33'(y_bottom_q);
	assign xdiff_neg = -xdiff;
	assign ydiff_neg = -ydiff;
	assign xdiff_mag = xdiff[32] ? xdiff_neg[31:0] : xdiff[31:0];
	assign ydiff_mag = ydiff[32] ? ydiff_neg[31:0] : ydiff[31:0];

	// restoring divider, one quotient bit per cycle, dividend shifts out of div_quo_q
	assign div_trial    = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge       = div_trial >= {1'b0, div_den_q};
	assign div_rem_next = div_ge ? DIV_W'(div_trial - {1'b0, div_den_q}) : div_trial[DIV_W-1:0];
	assign div_last     = div_cnt_q == CNT_W'(DIV_W - 1);
	assign quo_zero     = div_quo_q == '0;
	assign inside_h     = !hneg_q && (32'(row_q) < div_quo_q);

	always_comb begin
		case (state_q) inside
			S_MX: begin
				mul_a = signed'(MUL_W'(col_q));
				mul_b = step_q;
			end
			S_MY: begin
				mul_a = signed'(MUL_W'(row_q));
				mul_b = step_q;
			end
			S_XX: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			S_YY: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(y_q);
			end
			default: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(y_q);
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	// floor shift of the registered product
	assign prod_sh = prod_q[PROD_W-1:FRAC_BITS];

	assign start_x = sat32(SAT_W'(x_start_q) + SAT_W'(prod_q));
	assign start_y = sat32(SAT_W'(y_top_q) - SAT_W'(prod_q));

	assign esc_sum = EW'(xx_q) + EW'(yy_q);
	assign escape  = esc_sum >= FOUR;
	assign nx      = NW'(xx_q) - NW'(yy_q) + NW'(c_real_q);
	assign ny      = (NW'(prod_sh) <<< 1) + NW'(c_imag_q);
	assign next_x  = sat32(SAT_W'(nx));
	assign next_y  = sat32(SAT_W'(ny));

	assign iter_end = t_q == max_iter_q;
	assign t100     = {1'b0, t_q, 6'b0} + {2'b0, t_q, 5'b0} + {5'b0, t_q, 2'b0};
	assign rgb      = colour_map(LEVEL_TAB[div_quo_q[6:0]]);

	assign finish = (state_q == S_IDLE && accept && col_out)
		|| (state_q == S_STEP_END && quo_zero)
		|| (state_q == S_HGT_END && !inside_h)
		|| (state_q == S_XX && iter_end)
		|| (state_q == S_K_END);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (accept && !col_out) state_d = S_DIV_STEP;
			S_DIV_STEP: if (div_last) state_d = S_STEP_END;
			S_STEP_END: state_d = quo_zero ? S_IDLE : S_DIV_HGT;
			S_DIV_HGT:  if (div_last) state_d = S_HGT_END;
			S_HGT_END:  state_d = inside_h ? S_MX : S_IDLE;
			S_MX:       state_d = S_MY;
			S_MY:       state_d = S_Y0;
			S_Y0:       state_d = S_XX;
			S_XX:       state_d = iter_end ? S_IDLE : S_YY;
			S_YY:       state_d = S_XY;
			S_XY:       state_d = S_UPD;
			S_UPD:      state_d = escape ? S_DIV_K : S_XX;
			S_DIV_K:    if (div_last) state_d = S_K_END;
			S_K_END:    state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			div_cnt_q  <= '0;
			c_real_q   <= C_REAL_RST;
			c_imag_q   <= C_IMAG_RST;
			x_start_q  <= X_START_RST;
			x_end_q    <= X_END_RST;
			y_bottom_q <= Y_BOTTOM_RST;
			y_top_q    <= Y_TOP_RST;
			width_q    <= WIDTH_RST;
			max_iter_q <= MAX_ITER_RST;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (state_q == S_DIV_STEP || state_q == S_DIV_HGT || state_q == S_DIV_K) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_C_REAL:   c_real_q   <= cfg_data;
					CFG_C_IMAG:   c_imag_q   <= cfg_data;
					CFG_X_START:  x_start_q  <= cfg_data;
					CFG_X_END:    x_end_q    <= cfg_data;
					CFG_Y_BOTTOM: y_bottom_q <= cfg_data;
					CFG_Y_TOP:    y_top_q    <= cfg_data;
					CFG_WIDTH:    width_q    <= cfg_data[11:0];
					CFG_MAX_ITER: max_iter_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin
				if (accept) begin
					row_q      <= row;
					col_q      <= col;
					xneg_q     <= xdiff[32];
					div_quo_q  <= xdiff_mag;
					div_rem_q  <= '0;
					div_den_q  <= DIV_W'(width_q);
					red_q      <= '0;
					green_q    <= '0;
					blue_q     <= '0;
					in_image_q <= 1'b0;
				end
			end
			S_DIV_STEP, S_DIV_HGT, S_DIV_K: begin
				div_rem_q <= div_rem_next;
				div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
			end
			S_STEP_END: begin
				step_q    <= xneg_q ? signed'(MUL_W'(0) - {1'b0, div_quo_q})
				                    : signed'({1'b0, div_quo_q});
				// height sign: quotient sign of two signed operands
				hneg_q    <= ydiff[32] ^ xneg_q;
				div_quo_q <= ydiff_mag;
				div_rem_q <= '0;
				div_den_q <= div_quo_q;
			end
			S_MX: prod_q <= mul_p;
			S_MY: begin
				x_q    <= start_x;
				prod_q <= mul_p;
			end
			S_Y0: begin
				y_q <= start_y;
				t_q <= '0;
			end
			S_XX: begin
				prod_q <= mul_p;
				if (iter_end) in_image_q <= 1'b1;
			end
			S_YY: begin
				xx_q   <= prod_sh;
				prod_q <= mul_p;
			end
			S_XY: begin
				yy_q   <= prod_sh;
				prod_q <= mul_p;
			end
			S_UPD: begin
				if (escape) begin
					div_quo_q <= DIV_W'(t100);
					div_rem_q <= '0;
					div_den_q <= DIV_W'(max_iter_q);
				end else begin
					x_q <= next_x;
					y_q <= next_y;
					t_q <= t_q + 1'b1;
				end
			end
			S_K_END: begin
				red_q      <= rgb.r;
				green_q    <= rgb.g;
				blue_q     <= rgb.b;
				in_image_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign red      = red_q;
	assign green    = green_q;
	assign blue     = blue_q;
	assign in_image = in_image_q;

endmodule

@@ sv/jet_checker.sv @@
// Port-level checker for julia_escape_time_pixel, attached by bind.
// Depends on julia_escape_time_pixel_assert.svh for the assertion macros.
`include "julia_escape_time_pixel_assert.svh"

module jet_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       in_image
);

	// an accepted command either runs or reports at once
	`JET_ASSERT_NEXT(a_accept_runs, start && !busy, busy || done, "jet: accept lost")

	// a result is only shown once the sequencer is back in idle
	`JET_ASSERT_IMPL(a_done_idle, done, !busy, "jet: result while busy")

	// pixels outside the image are black
	`JET_ASSERT_IMPL(a_outside_black, done && !in_image,
		red == 8'd0 && green == 8'd0 && blue == 8'd0, "jet: outside pixel not black")

	// inside pixels are black or use the 55..255 palette
	`JET_ASSERT_IMPL(a_palette_range, done && in_image,
		(red == 8'd0 && green == 8'd0 && blue == 8'd0) ||
		(red >= 8'd55 && green >= 8'd55 && blue >= 8'd55), "jet: color out of range")

endmodule

bind julia_escape_time_pixel jet_checker u_jet_checker (.*);

@@ dv/tb_julia_escape_time_pixel.sv @@
// Testbench for julia_escape_time_pixel: a directed table, then randomized phases of
// window/constant settings and pixel commands, checked against fixed expectations or an in-bench predictor.
// Depends on jet_pkg and julia_escape_time_pixel.
module tb_julia_escape_time_pixel;
	import jet_pkg::*;

	localparam int COORD_W = 12;
	localparam int FRAC_W = 26;
	localparam int ONE = 67108864;                  // 1.0 in Q6.26
	localparam longint ESCAPE_R2 = 64'sd4 << FRAC_W;
	localparam int RANDOM_ITEMS = 400;
	localparam int unsigned CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       in_image;
	} pixel_t;

	typedef enum logic {PLAN_PIXEL, PLAN_WRITE} plan_kind_t;

	typedef struct packed {
		plan_kind_t   kind;
		cfg_idx_t     sel;
		logic [31:0]  value;
		logic [11:0]  y_pos;
		logic [11:0]  x_pos;
		logic         typed;
		pixel_t       want;
	} plan_row_t;

	localparam pixel_t OUTSIDE  = '{8'd0, 8'd0, 8'd0, 1'b0};
	localparam pixel_t BLACK_IN = '{8'd0, 8'd0, 8'd0, 1'b1};
	localparam pixel_t ESC_NOW  = '{8'd55, 8'd55, 8'd255, 1'b1};

	// floor(500*log10(n)) for n = 1..100
	localparam int unsigned LOG_LEVEL [0:99] = '{
		0, 150, 238, 301, 349, 389, 422, 451, 477, 500,
		520, 539, 556, 573, 588, 602, 615, 627, 639, 650,
		661, 671, 680, 690, 698, 707, 715, 723, 731, 738,
		745, 752, 759, 765, 772, 778, 784, 789, 795, 801,
		806, 811, 816, 821, 826, 831, 836, 840, 845, 849,
		853, 858, 862, 866, 870, 874, 877, 881, 885, 889,
		892, 896, 899, 903, 906, 909, 913, 916, 919, 922,
		925, 928, 931, 934, 937, 940, 943, 946, 948, 951,
		954, 956, 959, 962, 964, 967, 969, 972, 974, 977,
		979, 981, 984, 986, 988, 991, 993, 995, 997, 1000
	};

	localparam plan_row_t PLAN [0:50] = '{
		// power-on settings: window -2..2, 640 wide, 256 iterations, c = 0
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b1, ESC_NOW},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd640, 1'b1, OUTSIDE},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd640, 12'd0, 1'b1, OUTSIDE},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd4095, 12'd4095, 1'b1, OUTSIDE},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd320, 12'd320, 1'b1, BLACK_IN},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd639, 12'd639, 1'b1, ESC_NOW},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd100, 12'd200, 1'b0, '0},
		// c = -0.8 + 0.156i
		'{PLAN_WRITE, CFG_C_REAL, -32'sd53687091, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_C_IMAG, 32'sd10468982, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd320, 12'd100, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd200, 12'd300, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd400, 12'd500, 1'b0, '0},
		// no iterations at all: every pixel inside is black
		'{PLAN_WRITE, CFG_MAX_ITER, 32'd0, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd320, 12'd320, 1'b1, BLACK_IN},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b1, BLACK_IN},
		'{PLAN_WRITE, CFG_MAX_ITER, 32'd1, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b1, ESC_NOW},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd320, 12'd320, 1'b1, BLACK_IN},
		// full iteration limit, c = 0: the center never escapes
		'{PLAN_WRITE, CFG_MAX_ITER, 32'd65535, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_C_IMAG, 32'd0, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd320, 12'd320, 1'b1, BLACK_IN},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b1, ESC_NOW},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd100, 12'd200, 1'b0, '0},
		// zero width
		'{PLAN_WRITE, CFG_WIDTH, 32'd0, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b1, OUTSIDE},
		// widest image: 4095 x 4095
		'{PLAN_WRITE, CFG_WIDTH, 32'd4095, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd4094, 12'd4094, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd4095, 12'd4094, 1'b1, OUTSIDE},
		// window over the whole 32-bit range, one pixel
		'{PLAN_WRITE, CFG_X_START, 32'h8000_0000, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_X_END, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_Y_BOTTOM, 32'h8000_0000, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_Y_TOP, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_WIDTH, 32'd1, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd1, 12'd0, 1'b1, OUTSIDE},
		// step truncates to zero
		'{PLAN_WRITE, CFG_X_END, -32'sd2147483548, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_WIDTH, 32'd4095, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd0, 1'b1, OUTSIDE},
		// mirrored window (negative step) and extreme c to force clamping
		'{PLAN_WRITE, CFG_X_START, 32'sd134217728, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_X_END, -32'sd134217728, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_Y_BOTTOM, 32'sd134217728, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_Y_TOP, -32'sd134217728, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_WIDTH, 32'd64, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_C_REAL, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_C_IMAG, 32'h8000_0000, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_WRITE, CFG_MAX_ITER, 32'd16, 12'd0, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd32, 12'd32, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd33, 12'd31, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd63, 12'd0, 1'b0, '0},
		'{PLAN_PIXEL, CFG_C_REAL, 32'd0, 12'd0, 12'd64, 1'b1, OUTSIDE}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [COORD_W-1:0]  row = '0;
	logic [COORD_W-1:0]  col = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = CFG_C_REAL;
	logic [31:0]         cfg_data = '0;
	logic                done;
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;
	logic                in_image;

	// register image kept by the bench
	logic signed [31:0]  julia_re = 32'sd0;
	logic signed [31:0]  julia_im = 32'sd0;
	logic signed [31:0]  win_left = -32'sd134217728;
	logic signed [31:0]  win_right = 32'sd134217728;
	logic signed [31:0]  win_bottom = -32'sd134217728;
	logic signed [31:0]  win_top = 32'sd134217728;
	logic [11:0]         img_width = 12'd640;
	logic [15:0]         iter_cap = 16'd256;

	pixel_t              pending_colors [$];
	int                  mismatches = 0;
	int unsigned         cycles = 0;

	julia_escape_time_pixel #(.COORD_BITS(COORD_W), .FRAC_BITS(FRAC_W)) u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void frame_geometry(output longint stp, output longint hgt);
		stp = 0;
		hgt = 0;
		if (img_width != 0) stp = (longint'(win_right) - longint'(win_left)) / longint'(img_width);
		if (stp != 0) hgt = (longint'(win_top) - longint'(win_bottom)) / stp;
	endfunction

	// escape-time color of one pixel under the current register image
	function automatic pixel_t shade_pixel(input logic [11:0] r_i, input logic [11:0] c_i);
		pixel_t px;
		longint stp, hgt, zx, zy, sq_x, sq_y, xy_prod;
		int unsigned n, lvl;
		bit escaped;
		px = '0;
		frame_geometry(stp, hgt);
		if (!(longint'(c_i) < longint'(img_width) && longint'(r_i) < hgt)) return px;
		zx = clamp32(longint'(win_left) + longint'(c_i) * stp);
		zy = clamp32(longint'(win_top) - longint'(r_i) * stp);
		n = 0;
		escaped = 1'b0;
		while (n < iter_cap && !escaped) begin
			sq_x = (zx * zx) >>> FRAC_W;
			sq_y = (zy * zy) >>> FRAC_W;
			xy_prod = (zx * zy) >>> FRAC_W;
			if (sq_x + sq_y >= ESCAPE_R2) begin
				escaped = 1'b1;
			end else begin
				zx = clamp32(sq_x - sq_y + longint'(julia_re));
				zy = clamp32(2 * xy_prod + longint'(julia_im));
				n++;
			end
		end
		px.in_image = 1'b1;
		if (n == iter_cap) return px;
		lvl = LOG_LEVEL[(100 * n) / iter_cap];
		if (lvl > 800) begin
			px.red = 8'd255;
			px.green = 8'(55 + lvl - 800);
			px.blue = 8'(55 + lvl - 800);
		end else if (lvl > 600) begin
			px.red = 8'd255;
			px.green = 8'(255 - (lvl - 600));
			px.blue = 8'd55;
		end else if (lvl > 400) begin
			px.red = 8'(55 + lvl - 400);
			px.green = 8'd255;
			px.blue = 8'd55;
		end else if (lvl > 200) begin
			px.red = 8'd55;
			px.green = 8'd255;
			px.blue = 8'(255 - (lvl - 200));
		end else begin
			px.red = 8'd55;
			px.green = 8'(55 + lvl);
			px.blue = 8'd255;
		end
		return px;
	endfunction

	// leaves cfg_valid high so writes can go back to back; caller drops it
	task automatic set_register(input cfg_idx_t sel, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			CFG_C_REAL:   julia_re = val;
			CFG_C_IMAG:   julia_im = val;
			CFG_X_START:  win_left = val;
			CFG_X_END:    win_right = val;
			CFG_Y_BOTTOM: win_bottom = val;
			CFG_Y_TOP:    win_top = val;
			CFG_WIDTH:    img_width = val[11:0];
			CFG_MAX_ITER: iter_cap = val[15:0];
			default:      ;
		endcase
	endtask

	// gap == 0 keeps start high for a pixel that follows right away
	task automatic send_pixel(input logic [11:0] r_i, input logic [11:0] c_i, input int gap,
			input logic typed, input pixel_t want);
		start <= 1'b1;
		row <= r_i;
		col <= c_i;
		do @(posedge clk); while (busy);
		pending_colors.push_back(typed ? want : shade_pixel(r_i, c_i));
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_idle();
		while (pending_colors.size() != 0 || busy) @(posedge clk);
	endtask

	function automatic void check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		pixel_t want;
		if (arst_n && done) begin
			if (pending_colors.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got %0d/%0d/%0d in_image %0b",
					$time, red, green, blue, in_image);
			end else begin
				want = pending_colors.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("in_image", 8'(want.in_image), 8'(in_image));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_julia_escape_time_pixel: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		bit cfg_open;
		int rnd_sent, n_items, gap, lft, bot;
		bit quiet_run, aimed;
		longint stp, hgt, rows_in;
		logic [11:0] r_pick, c_pick;
		cfg_open = 1'b0;
		rnd_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(PLAN); i++) begin
			if (PLAN[i].kind == PLAN_WRITE) begin
				if (!cfg_open) wait_for_idle();
				set_register(PLAN[i].sel, PLAN[i].value);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				send_pixel(PLAN[i].y_pos, PLAN[i].x_pos, $urandom_range(1, 3), PLAN[i].typed,
					PLAN[i].want);
			end
		end

		while (rnd_sent < RANDOM_ITEMS) begin
			wait_for_idle();
			repeat ($urandom_range(0, 4)) @(posedge clk);
			if ($urandom_range(0, 9) < 7) begin
				// plausible views around the set, c within +-1.0
				lft = -int'($urandom_range(ONE / 2, 5 * ONE / 2));
				bot = -int'($urandom_range(ONE / 2, 5 * ONE / 2));
				set_register(CFG_C_REAL, $urandom_range(0, 2 * ONE) - ONE);
				set_register(CFG_C_IMAG, $urandom_range(0, 2 * ONE) - ONE);
				set_register(CFG_X_START, lft);
				set_register(CFG_X_END, lft + int'($urandom_range(ONE, 4 * ONE)));
				set_register(CFG_Y_BOTTOM, bot);
				set_register(CFG_Y_TOP, bot + int'($urandom_range(ONE, 4 * ONE)));
				set_register(CFG_WIDTH, $urandom_range(1, ($urandom_range(0, 3) == 0) ? 400 : 64));
				set_register(CFG_MAX_ITER, ($urandom_range(0, 7) == 0) ?
					$urandom_range(150, 300) : $urandom_range(1, 80));
			end else begin
				set_register(CFG_C_REAL, $urandom);
				set_register(CFG_C_IMAG, $urandom);
				set_register(CFG_X_START, $urandom);
				set_register(CFG_X_END, $urandom);
				set_register(CFG_Y_BOTTOM, $urandom);
				set_register(CFG_Y_TOP, $urandom);
				set_register(CFG_WIDTH, $urandom_range(0, 4095));
				set_register(CFG_MAX_ITER, $urandom_range(0, 300));
			end
			cfg_valid <= 1'b0;

			frame_geometry(stp, hgt);
			rows_in = (hgt > 4096) ? 4096 : hgt;
			n_items = $urandom_range(20, 45);
			quiet_run = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < n_items; k++) begin
				aimed = rows_in > 0 && img_width != 0 && $urandom_range(0, 7) != 0;
				if (aimed) begin
					r_pick = $urandom_range(0, int'(rows_in) - 1);
					c_pick = $urandom_range(0, img_width - 1);
				end else begin
					r_pick = $urandom_range(0, 4095);
					c_pick = $urandom_range(0, 4095);
				end
				if (quiet_run) gap = 0;
				else if ($urandom_range(0, 9) == 0) gap = $urandom_range(15, 60);
				else gap = $urandom_range(0, 3);
				if (k == n_items - 1 && gap == 0) gap = 1;
				send_pixel(r_pick, c_pick, gap, 1'b0, '0);
				rnd_sent++;
			end
		end

		wait_for_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_julia_escape_time_pixel: done, clean");
		else
			$display("tb_julia_escape_time_pixel: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/jet_pkg.sv
sv/julia_escape_time_pixel.sv
sv/jet_checker.sv
dv/tb_julia_escape_time_pixel.sv
